### sv/rssg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rssg_pkg
// Shared types and constants of the reversing screw step generator.
// ----------------------------------------------------------------------------
package rssg_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // Register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ACCEL_STEP     = 2'd0,
        CFG_LOWER_LIMIT    = 2'd1,
        CFG_UPPER_LIMIT    = 2'd2,
        CFG_PRELOAD_OFFSET = 2'd3
    } cfg_index_t;

    // Register reset values
    localparam logic [15:0] ACCEL_STEP_RST     = 16'd8;
    localparam logic [31:0] LOWER_LIMIT_RST    = 32'd48986000;
    localparam logic [31:0] UPPER_LIMIT_RST    = 32'd311122000;
    localparam logic [30:0] PRELOAD_OFFSET_RST = 31'd28000000;

    // Operating modes
    typedef enum logic [1:0] {
        MODE_INDEX = 2'd0,
        MODE_SWEEP = 2'd1,
        MODE_MOVE  = 2'd2,
        MODE_TRACK = 2'd3
    } mode_t;

    typedef struct packed {
        logic [15:0]        accel_step;
        logic signed [31:0] lower_limit;
        logic signed [31:0] upper_limit;
        logic [30:0]        preload_offset;
    } cfg_t;

    typedef struct packed {
        logic encoder_edge;
        logic edge_direction;
        logic index_tick;
        logic inner_limit;
        logic outer_limit;
    } event_t;

    typedef struct packed {
        logic               step_pulse;
        logic               step_direction;
        logic               fast_index;
        logic [1:0]         mode;
        logic signed [31:0] position;
    } result_t;

endpackage
`default_nettype wire

### sv/rssg_channels.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rssg channels
// Valid/ready channels for event items and result items.
// ----------------------------------------------------------------------------
interface rssg_event_if;
    logic valid;
    logic ready;
    logic encoder_edge;
    logic edge_direction;
    logic index_tick;
    logic inner_limit;
    logic outer_limit;

    modport source (output valid, encoder_edge, edge_direction, index_tick,
                    inner_limit, outer_limit, input ready);
    modport sink   (input valid, encoder_edge, edge_direction, index_tick,
                    inner_limit, outer_limit, output ready);
endinterface

interface rssg_result_if;
    logic               valid;
    logic               ready;
    logic               step_pulse;
    logic               step_direction;
    logic               fast_index;
    logic [1:0]         mode;
    logic signed [31:0] position;

    modport source (output valid, step_pulse, step_direction, fast_index,
                    mode, position, input ready);
    modport sink   (input valid, step_pulse, step_direction, fast_index,
                    mode, position, output ready);
endinterface
`default_nettype wire

### sv/rssg_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rssg_cfg
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module rssg_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [rssg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [rssg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output rssg_pkg::cfg_t                          cfg
);

    rssg_pkg::cfg_t cfg_reg;
    rssg_pkg::cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (rssg_pkg::cfg_index_t'(cfg_index))
                rssg_pkg::CFG_ACCEL_STEP:     cfg_next.accel_step     = cfg_wdata[15:0];
                rssg_pkg::CFG_LOWER_LIMIT:    cfg_next.lower_limit    = cfg_wdata;
                rssg_pkg::CFG_UPPER_LIMIT:    cfg_next.upper_limit    = cfg_wdata;
                rssg_pkg::CFG_PRELOAD_OFFSET: cfg_next.preload_offset = cfg_wdata[30:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_step     <= rssg_pkg::ACCEL_STEP_RST;
            cfg_reg.lower_limit    <= rssg_pkg::LOWER_LIMIT_RST;
            cfg_reg.upper_limit    <= rssg_pkg::UPPER_LIMIT_RST;
            cfg_reg.preload_offset <= rssg_pkg::PRELOAD_OFFSET_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

### sv/rssg_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rssg_step
// Mode machine and screw emulation state; one event is applied per fire.
// ----------------------------------------------------------------------------
module rssg_step (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire rssg_pkg::cfg_t    cfg,
    input  wire rssg_pkg::event_t  ev,
    output rssg_pkg::result_t      res
);

    rssg_pkg::mode_t    mode_reg, mode_next;
    logic [31:0]        position_reg, position_next;
    logic [31:0]        velocity_reg, velocity_next;
    logic               drum_dir_reg, drum_dir_next;
    logic               drum_dir_prev_reg, drum_dir_prev_next;
    logic [15:0]        high_prev_reg, high_prev_next;

    logic               preload;
    logic               run;
    logic               fast;
    logic               vel_zero;
    logic [31:0]        pos_base;
    logic [15:0]        high_base;
    logic [31:0]        accel_ext;
    logic [31:0]        pos_sum;

    assign vel_zero  = (velocity_reg == 32'd0);
    assign preload   = ev.index_tick && (mode_reg == rssg_pkg::MODE_INDEX) && ev.inner_limit;
    assign accel_ext = {16'd0, cfg.accel_step};

    // Mode machine: next mode
    always_comb
    begin
        mode_next = mode_reg;
        if (ev.index_tick)
        begin
            case (mode_reg)
                rssg_pkg::MODE_INDEX: if (ev.inner_limit) mode_next = rssg_pkg::MODE_SWEEP;
                rssg_pkg::MODE_SWEEP: if (ev.outer_limit) mode_next = rssg_pkg::MODE_MOVE;
                rssg_pkg::MODE_MOVE:  if (vel_zero) mode_next = rssg_pkg::MODE_TRACK;
                default:              mode_next = mode_reg;
            endcase
        end
    end

    // Mode machine: run and fast-index decisions
    always_comb
    begin
        run  = ev.encoder_edge && (mode_reg == rssg_pkg::MODE_TRACK);
        fast = 1'b0;
        if (ev.index_tick)
        begin
            case (mode_reg)
                rssg_pkg::MODE_INDEX: run = 1'b1;
                rssg_pkg::MODE_SWEEP:
                begin
                    run  = 1'b1;
                    fast = vel_zero;
                end
                rssg_pkg::MODE_MOVE:  if (!vel_zero) run = 1'b1;
                default:              fast = 1'b0;
            endcase
        end
    end

    // Preload the position from the upper limit in index mode
    assign pos_base  = preload ? (cfg.upper_limit - {1'b0, cfg.preload_offset})
                               : position_reg;
    assign high_base = preload ? pos_base[31:16] : high_prev_reg;

    // Latch the drum direction from a tracked encoder edge
    assign drum_dir_next = (ev.encoder_edge && (mode_reg == rssg_pkg::MODE_TRACK))
                         ? ev.edge_direction : drum_dir_reg;

    // Bend or reverse the velocity, then advance the position
    always_comb
    begin
        velocity_next      = velocity_reg;
        drum_dir_prev_next = drum_dir_prev_reg;
        if (run)
        begin
            if (drum_dir_next != drum_dir_prev_reg)
            begin
                drum_dir_prev_next = drum_dir_next;
                velocity_next      = 32'd0 - velocity_reg;
            end
            else if ($signed(pos_base) >= cfg.upper_limit)
            begin
                velocity_next = velocity_reg - accel_ext;
            end
            else if ($signed(pos_base) <= cfg.lower_limit)
            begin
                velocity_next = velocity_reg + accel_ext;
            end
        end
    end

    assign pos_sum        = pos_base + velocity_next;
    assign position_next  = run ? pos_sum : pos_base;
    assign high_prev_next = run ? pos_sum[31:16] : high_base;

    // Result of this event
    always_comb
    begin
        res.step_pulse     = run && (pos_sum[31:16] != high_base);
        res.step_direction = (velocity_next[31:16] != 16'd0);
        res.fast_index     = fast;
        res.mode           = mode_next;
        res.position       = position_next;
    end

    // Commit the state when the event is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= rssg_pkg::MODE_INDEX;
            position_reg      <= 32'd0;
            velocity_reg      <= 32'd0;
            drum_dir_reg      <= 1'b0;
            drum_dir_prev_reg <= 1'b0;
            high_prev_reg     <= 16'd0;
        end
        else if (fire)
        begin
            mode_reg          <= mode_next;
            position_reg      <= position_next;
            velocity_reg      <= velocity_next;
            drum_dir_reg      <= drum_dir_next;
            drum_dir_prev_reg <= drum_dir_prev_next;
            high_prev_reg     <= high_prev_next;
        end
    end

endmodule
`default_nettype wire

### sv/reversing_screw_step_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// A taken event is held in the event register; its result then moves to the
// result register, from which it is offered, once that slot is free or draining.
// Throughput: one event per cycle unless the result side stalls; the
// emulation state is updated as an event moves to the result register.
// Reset (rst_n low, asynchronous): index mode, position, velocity and drum
// state cleared, registers at their default values, no item held.
// ----------------------------------------------------------------------------
// reversing_screw_step_generator
// Reversing level-wind screw emulation producing stepper pulses.
// ----------------------------------------------------------------------------
module reversing_screw_step_generator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [rssg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [rssg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    rssg_event_if.sink                             item_in,
    rssg_result_if.source                          item_out
);

    rssg_pkg::cfg_t    cfg;
    rssg_pkg::event_t  ev_reg;
    rssg_pkg::result_t res;
    rssg_pkg::result_t res_reg;
    logic              ev_valid_reg, ev_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              take;
    logic              advance;

    rssg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rssg_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .cfg   (cfg),
        .ev    (ev_reg),
        .res   (res)
    );

    // Move an item forward when the result slot is free or being drained
    assign advance      = ev_valid_reg && (!out_valid_reg || item_out.ready);
    assign item_in.ready = !ev_valid_reg || advance;
    assign take         = item_in.valid && item_in.ready;

    always_comb
    begin
        ev_valid_next = ev_valid_reg;
        if (take)
            ev_valid_next = 1'b1;
        else if (advance)
            ev_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (item_out.ready)
            out_valid_next = 1'b0;
    end

    // Hold the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ev_valid_reg  <= ev_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the event and the result payloads
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ev_reg.encoder_edge   <= item_in.encoder_edge;
            ev_reg.edge_direction <= item_in.edge_direction;
            ev_reg.index_tick     <= item_in.index_tick;
            ev_reg.inner_limit    <= item_in.inner_limit;
            ev_reg.outer_limit    <= item_in.outer_limit;
        end
        if (advance)
            res_reg <= res;
    end

    assign item_out.valid          = out_valid_reg;
    assign item_out.step_pulse     = res_reg.step_pulse;
    assign item_out.step_direction = res_reg.step_direction;
    assign item_out.fast_index     = res_reg.fast_index;
    assign item_out.mode           = res_reg.mode;
    assign item_out.position       = res_reg.position;

endmodule
`default_nettype wire

### dv/tb_reversing_screw_step_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reversing_screw_step_generator
// Self-checking bench: walks the mode machine through index, sweep, move and
// track with directed events, then drives random drum edges under several
// limit settings, idle profiles and backpressure, and checks every result
// item against a cycle-free emulation of the screw.
// ----------------------------------------------------------------------------
module tb_reversing_screw_step_generator;

    localparam int          CYCLE_LIMIT = 100000;
    localparam int          DRAIN_PAD   = 4;
    localparam logic [31:0] POS_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MIN     = 32'h8000_0000;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_we;
    logic [rssg_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rssg_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    rssg_event_if  ev_ch ();
    rssg_result_if res_ch ();

    reversing_screw_step_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item_in   (ev_ch),
        .item_out  (res_ch)
    );

    // Clock
    always #5 clk = ~clk;

    // Screw emulation state and register copy
    rssg_pkg::mode_t    scr_mode;
    logic signed [31:0] scr_pos;
    logic [31:0]        scr_vel;
    logic               scr_dir;
    logic               scr_dir_prev;
    logic [15:0]        scr_high_prev;
    logic [15:0]        reg_accel;
    logic signed [31:0] reg_lower;
    logic signed [31:0] reg_upper;
    logic [30:0]        reg_preload;

    rssg_pkg::result_t pending_results[$];
    int      error_count   = 0;
    int      src_idle_pct  = 0;
    int      sink_idle_pct = 0;
    int      hold_request  = 0;
    int      cycle_count   = 0;

    // Load the reset state into the emulation
    task automatic reset_screw();
        scr_mode      = rssg_pkg::MODE_INDEX;
        scr_pos       = '0;
        scr_vel       = '0;
        scr_dir       = 1'b0;
        scr_dir_prev  = 1'b0;
        scr_high_prev = '0;
        reg_accel     = rssg_pkg::ACCEL_STEP_RST;
        reg_lower     = rssg_pkg::LOWER_LIMIT_RST;
        reg_upper     = rssg_pkg::UPPER_LIMIT_RST;
        reg_preload   = rssg_pkg::PRELOAD_OFFSET_RST;
    endtask

    // Advance the screw emulation by one event and return its result item
    function automatic rssg_pkg::result_t screw_step(input rssg_pkg::event_t ev);
        logic              run;
        rssg_pkg::result_t r;
        run = 1'b0;
        r   = '0;
        // the edge is judged in the mode before any tick
        if (ev.encoder_edge && scr_mode == rssg_pkg::MODE_TRACK)
        begin
            run     = 1'b1;
            scr_dir = ev.edge_direction;
        end
        if (ev.index_tick)
        begin
            case (scr_mode)
                rssg_pkg::MODE_INDEX:
                begin
                    if (ev.inner_limit)
                    begin
                        scr_pos       = reg_upper - {1'b0, reg_preload};
                        scr_high_prev = scr_pos[31:16];
                        scr_mode      = rssg_pkg::MODE_SWEEP;
                    end
                    run = 1'b1;
                end
                rssg_pkg::MODE_SWEEP:
                begin
                    if (scr_vel == '0)
                        r.fast_index = 1'b1;
                    if (ev.outer_limit)
                        scr_mode = rssg_pkg::MODE_MOVE;
                    run = 1'b1;
                end
                rssg_pkg::MODE_MOVE:
                begin
                    if (scr_vel == '0)
                        scr_mode = rssg_pkg::MODE_TRACK;
                    else
                        run = 1'b1;
                end
                default: ;
            endcase
        end
        // reverse on a drum reversal, else bend the velocity beyond a limit
        if (run)
        begin
            if (scr_dir != scr_dir_prev)
            begin
                scr_dir_prev = scr_dir;
                scr_vel      = '0 - scr_vel;
            end
            else if (scr_pos >= reg_upper)
            begin
                scr_vel = scr_vel - {16'd0, reg_accel};
            end
            else if (scr_pos <= reg_lower)
            begin
                scr_vel = scr_vel + {16'd0, reg_accel};
            end
            scr_pos = scr_pos + scr_vel;
            if (scr_pos[31:16] != scr_high_prev)
            begin
                scr_high_prev = scr_pos[31:16];
                r.step_pulse  = 1'b1;
            end
        end
        r.step_direction = (scr_vel[31:16] != '0);
        r.mode           = scr_mode;
        r.position       = scr_pos;
        return r;
    endfunction

    function automatic rssg_pkg::event_t make_event(input logic edge_bit, input logic dir,
                                                    input logic tick, input logic inner,
                                                    input logic outer);
        rssg_pkg::event_t ev;
        ev.encoder_edge   = edge_bit;
        ev.edge_direction = dir;
        ev.index_tick     = tick;
        ev.inner_limit    = inner;
        ev.outer_limit    = outer;
        return ev;
    endfunction

    // Offer one event item, hold it until taken, then queue its result
    task automatic send_event(input rssg_pkg::event_t ev);
        while ($urandom_range(99) < src_idle_pct)
        begin
            ev_ch.valid <= 1'b0;
            @(posedge clk);
        end
        ev_ch.valid          <= 1'b1;
        ev_ch.encoder_edge   <= ev.encoder_edge;
        ev_ch.edge_direction <= ev.edge_direction;
        ev_ch.index_tick     <= ev.index_tick;
        ev_ch.inner_limit    <= ev.inner_limit;
        ev_ch.outer_limit    <= ev.outer_limit;
        do
            @(posedge clk);
        while (!ev_ch.ready);
        pending_results.push_back(screw_step(ev));
    endtask

    // Stop offering and wait until every queued result item has arrived
    task automatic drain_results();
        ev_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    // Write one register; the block must be idle
    task automatic write_reg(input rssg_pkg::cfg_index_t idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            rssg_pkg::CFG_ACCEL_STEP:     reg_accel   = data[15:0];
            rssg_pkg::CFG_LOWER_LIMIT:    reg_lower   = data;
            rssg_pkg::CFG_UPPER_LIMIT:    reg_upper   = data;
            rssg_pkg::CFG_PRELOAD_OFFSET: reg_preload = data[30:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Random drum edges with noise on the other fields; count only runs
    task automatic send_drum_edges(input int n_runs, input int flip_odds);
        int               runs;
        rssg_pkg::event_t ev;
        runs = 0;
        while (runs < n_runs)
        begin
            ev.encoder_edge   = ($urandom_range(9) < 8);
            ev.edge_direction = ($urandom_range(flip_odds - 1) == 0) ? ~scr_dir : scr_dir;
            ev.index_tick     = 1'($urandom_range(1));
            ev.inner_limit    = 1'($urandom_range(1));
            ev.outer_limit    = 1'($urandom_range(1));
            send_event(ev);
            if (ev.encoder_edge)
                runs++;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected 0x%08h, actual 0x%08h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Result sink: check each taken item, drive ready with idling and hold-off
    initial
    begin : result_sink
        int                hold_left;
        rssg_pkg::result_t exp_r;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result item with no expectation waiting");
                    error_count++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    check_field("step_pulse", 32'(exp_r.step_pulse), 32'(res_ch.step_pulse));
                    check_field("step_direction", 32'(exp_r.step_direction),
                                32'(res_ch.step_direction));
                    check_field("fast_index", 32'(exp_r.fast_index), 32'(res_ch.fast_index));
                    check_field("mode", 32'(exp_r.mode), 32'(res_ch.mode));
                    check_field("position", exp_r.position, res_ch.position);
                end
            end
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Watchdog
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // An edge in index mode is ignored and must not load the drum direction
    task automatic test_reset_state();
        send_event(make_event(1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
        drain_results();
    endtask

    // Index ticks run the screw; the inner switch preloads and enters sweep
    task automatic test_index_mode();
        write_reg(rssg_pkg::CFG_ACCEL_STEP, 32'd0);
        send_event(make_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        send_event(make_event(1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
        send_event(make_event(1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
    endtask

    // Fast index at zero velocity, outer switch without and with a tick
    task automatic test_sweep_mode();
        send_event(make_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        send_event(make_event(1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
        send_event(make_event(1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        drain_results();
        // every position is at or above the most negative upper limit
        write_reg(rssg_pkg::CFG_ACCEL_STEP, 32'd65535);
        write_reg(rssg_pkg::CFG_UPPER_LIMIT, NEG_MIN);
        send_event(make_event(1'b1, 1'b0, 1'b1, 1'b1, 1'b0));
        send_event(make_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        send_event(make_event(1'b0, 1'b1, 1'b1, 1'b0, 1'b1));
    endtask

    // Move ticks run until the velocity is back at zero, then track
    task automatic test_move_mode();
        int guard;
        guard = 0;
        drain_results();
        write_reg(rssg_pkg::CFG_UPPER_LIMIT, POS_MAX);
        write_reg(rssg_pkg::CFG_LOWER_LIMIT, POS_MAX);
        while (scr_mode == rssg_pkg::MODE_MOVE && guard < 40)
        begin
            send_event(make_event(1'b1, 1'b0, 1'b1, guard[0], ~guard[0]));
            guard++;
        end
    endtask

    // Ticks do nothing in track; edges run, a direction change reverses
    task automatic test_track_mode();
        send_event(make_event(1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
        send_event(make_event(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
        send_event(make_event(1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
        send_event(make_event(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    endtask

    // Bounce between limits placed around the current position
    task automatic test_random_bounce();
        int span;
        span = $urandom_range(2000000, 200000);
        drain_results();
        write_reg(rssg_pkg::CFG_ACCEL_STEP, $urandom_range(4000, 500));
        write_reg(rssg_pkg::CFG_LOWER_LIMIT, scr_pos - span);
        write_reg(rssg_pkg::CFG_UPPER_LIMIT, scr_pos + span);
        write_reg(rssg_pkg::CFG_PRELOAD_OFFSET, 32'd0);
        send_drum_edges(250, 12);
    endtask

    // Accelerate hard in one direction until the position wraps
    task automatic test_position_wrap();
        src_idle_pct  = 70;
        sink_idle_pct = 7;
        drain_results();
        write_reg(rssg_pkg::CFG_ACCEL_STEP, 32'd65535);
        write_reg(rssg_pkg::CFG_LOWER_LIMIT, POS_MAX);
        write_reg(rssg_pkg::CFG_UPPER_LIMIT, POS_MAX);
        send_drum_edges(280, 200);
    endtask

    // Widest limits and no acceleration: only reversals change the velocity
    task automatic test_constant_velocity();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        drain_results();
        write_reg(rssg_pkg::CFG_ACCEL_STEP, 32'd0);
        write_reg(rssg_pkg::CFG_LOWER_LIMIT, NEG_MIN);
        write_reg(rssg_pkg::CFG_UPPER_LIMIT, POS_MAX);
        write_reg(rssg_pkg::CFG_PRELOAD_OFFSET, POS_MAX);
        send_drum_edges(120, 4);
    endtask

    // Hold off the sink so the block fills, then pause the source mid-phase
    task automatic test_backpressure();
        logic [31:0] lim_a;
        logic [31:0] lim_b;
        logic [31:0] lim_t;
        lim_a = $urandom;
        lim_b = $urandom;
        if ($signed(lim_a) > $signed(lim_b))
        begin
            lim_t = lim_a;
            lim_a = lim_b;
            lim_b = lim_t;
        end
        drain_results();
        write_reg(rssg_pkg::CFG_ACCEL_STEP, $urandom_range(65535, 1));
        write_reg(rssg_pkg::CFG_LOWER_LIMIT, lim_a);
        write_reg(rssg_pkg::CFG_UPPER_LIMIT, lim_b);
        hold_request = 300;
        send_drum_edges(50, 8);
        send_drum_edges(80, 8);
        drain_results();
        send_drum_edges(80, 8);
    endtask

    // Stimulus
    initial
    begin : stimulus
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= rssg_pkg::CFG_ACCEL_STEP;
        cfg_wdata            <= '0;
        ev_ch.valid          <= 1'b0;
        ev_ch.encoder_edge   <= 1'b0;
        ev_ch.edge_direction <= 1'b0;
        ev_ch.index_tick     <= 1'b0;
        ev_ch.inner_limit    <= 1'b0;
        ev_ch.outer_limit    <= 1'b0;
        reset_screw();
        src_idle_pct  = 7;
        sink_idle_pct = 70;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_state();
        test_index_mode();
        test_sweep_mode();
        test_move_mode();
        test_track_mode();
        test_random_bounce();
        test_position_wrap();
        test_constant_velocity();
        test_backpressure();

        drain_results();
        repeat (8) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
sv/rssg_pkg.sv
sv/rssg_channels.sv
sv/rssg_cfg.sv
sv/rssg_step.sv
sv/reversing_screw_step_generator.sv
dv/tb_reversing_screw_step_generator.sv
